[sv/iocq_pkg.sv]
// In-order completion queue: shared constants, codes and types.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package iocq_pkg;

  // Ring geometry
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 64;
  localparam int PEND_W = 11;
  localparam int MODE_W = 2;

  // Request codes
  localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;

  // One ring slot: live flag plus stored id
  typedef struct packed {
    logic            live;
    logic [ID_W-1:0] id;
  } entry_t;

  // Controls from the sequencer to the chain
  typedef struct packed {
    logic             shift;     // every cell takes its right neighbor
    logic             load;      // write one cell at load_idx
    logic [IDX_W-1:0] load_idx;
    logic [ID_W-1:0]  load_id;
    entry_t           wrap;      // word fed into the last cell on a shift
  } chain_ctl_t;

  // Controls of a single cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/iocq_cell.sv]
// One slot of the completion queue chain: a live flag and an id.
// Depends on iocq_pkg.
`default_nettype none

module iocq_cell
  import iocq_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cell_ctl_t       ctl,
  input  wire entry_t          nbr,      // right neighbor's word
  input  wire logic [ID_W-1:0] load_id,
  output entry_t               q
);

  logic            live_r, live_nxt;
  logic [ID_W-1:0] id_r, id_nxt;

  // shift and load never come together
  always_comb begin
    live_nxt = live_r;
    id_nxt   = id_r;
    if (ctl.shift) begin
      live_nxt = nbr.live;
      id_nxt   = nbr.id;
    end else if (ctl.load) begin
      live_nxt = 1'b1;
      id_nxt   = load_id;
    end
  end

  // live flag is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  // id is payload, no reset
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign q.live = live_r;
  assign q.id   = id_r;

endmodule

`default_nettype wire

[sv/iocq_chain.sv]
// Row of DEPTH queue cells; cell 0 is always the ring head.
// Depends on iocq_pkg and iocq_cell.
`default_nettype none

module iocq_chain
  import iocq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chain_ctl_t ctl,
  output entry_t          head
);

  entry_t cell_q [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_ctl_t cctl;
      entry_t    nbr;

      // load decode at the tail slot
      assign cctl.shift = ctl.shift;
      assign cctl.load  = ctl.load && (ctl.load_idx == IDX_W'(gi));

      // last cell takes the wrapped head word
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = ctl.wrap;
      end else begin : g_mid
        assign nbr = cell_q[gi+1];
      end

      iocq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cctl),
        .nbr     (nbr),
        .load_id (ctl.load_id),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  assign head = cell_q[0];

endmodule

`default_nettype wire

[sv/iocq_ctrl.sv]
// Sequencer of the completion queue: request decode, scan, retire, result word.
// Depends on iocq_pkg; drives the chain through chain_ctl_t.
`default_nettype none

module iocq_ctrl
  import iocq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [ID_W-1:0]   in_event_id,
  output logic                   busy,
  input  wire entry_t            head,
  output chain_ctl_t             chain_ctl,
  output logic                   out_valid,
  output logic                   out_ok,
  output logic [ID_W-1:0]        out_oldest_id,
  output logic [PEND_W-1:0]      out_pending
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_RETIRE = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    step_r, step_nxt;
  logic                found_r, found_nxt;
  logic                ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [ID_W-1:0]     out_oldest_r, out_oldest_nxt;
  logic [PEND_W-1:0]   out_pending_r, out_pending_nxt;
  logic                hit;
  logic                id_zero;
  logic                empty;

  assign id_zero = (id_r == '0);
  assign empty   = (count_r == '0);

  // first live match while scanning past the head
  assign hit = !found_r && head.live && (head.id == id_r);

  // next-state and datapath control
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    id_nxt          = id_r;
    count_nxt       = count_r;
    step_nxt        = step_r;
    found_nxt       = found_r;
    ok_nxt          = ok_r;
    out_valid_nxt   = 1'b0;
    out_ok_nxt      = out_ok_r;
    out_oldest_nxt  = out_oldest_r;
    out_pending_nxt = out_pending_r;
    chain_ctl          = '0;
    chain_ctl.load_idx = count_r[IDX_W-1:0];
    chain_ctl.load_id  = id_r;
    chain_ctl.wrap     = head;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          id_nxt    = in_event_id;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ok_nxt    = 1'b0;
        state_nxt = ST_REPORT;
        unique case (mode_r)
          MODE_REGISTER: begin
            // append at tail unless full or id zero
            if (!id_zero && (count_r < CNT_W'(DEPTH))) begin
              chain_ctl.load = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              ok_nxt         = 1'b1;
            end
          end
          MODE_CHECK: begin
            // head is always live when the ring is not empty
            ok_nxt = id_zero || empty || (head.live && (head.id == id_r));
          end
          MODE_COMPLETE: begin
            if (!id_zero) begin
              step_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end

      ST_SCAN: begin
        // full rotation; the matching word goes back dead
        chain_ctl.shift     = 1'b1;
        chain_ctl.wrap.live = head.live && !hit;
        if (hit) begin
          found_nxt = 1'b1;
        end
        step_nxt = step_r + IDX_W'(1);
        if (step_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_RETIRE;
        end
      end

      ST_RETIRE: begin
        // drop completed words from the head one per cycle
        if (!empty && !head.live) begin
          chain_ctl.shift = 1'b1;
          count_nxt       = count_r - CNT_W'(1);
        end else begin
          ok_nxt    = found_r;
          state_nxt = ST_REPORT;
        end
      end

      ST_REPORT: begin
        out_valid_nxt   = 1'b1;
        out_ok_nxt      = ok_r;
        out_oldest_nxt  = (!empty && head.live) ? head.id : '0;
        out_pending_nxt = PEND_W'(count_r);
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    id_r          <= id_nxt;
    step_r        <= step_nxt;
    found_r       <= found_nxt;
    ok_r          <= ok_nxt;
    out_ok_r      <= out_ok_nxt;
    out_oldest_r  <= out_oldest_nxt;
    out_pending_r <= out_pending_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_oldest_id = out_oldest_r;
  assign out_pending   = out_pending_r;

endmodule

`default_nettype wire

[sv/in_order_completion_queue_top.sv]
// Register, turn check, id zero and unused mode: EXEC, then REPORT, then the result strobe.
// Complete: EXEC, a full rotation of the cell chain in SCAN, a final retire check plus
// one retire step per retired head word, then REPORT; busy is high until the result word is out.
// One request at a time; the next start is taken the cycle the result strobe shows.
// Synchronous active-low reset empties the ring and clears all live flags; receiver cannot stall.
`default_nettype none

module in_order_completion_queue_top
  import iocq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [ID_W-1:0]   in_event_id,
  output logic                   out_valid,
  output logic                   out_ok,
  output logic [ID_W-1:0]        out_oldest_id,
  output logic [PEND_W-1:0]      out_pending
);

  chain_ctl_t chain_ctl;
  entry_t     head;

  // sequencer
  iocq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_mode       (in_mode),
    .in_event_id   (in_event_id),
    .busy          (busy),
    .head          (head),
    .chain_ctl     (chain_ctl),
    .out_valid     (out_valid),
    .out_ok        (out_ok),
    .out_oldest_id (out_oldest_id),
    .out_pending   (out_pending)
  );

  // ring of cells
  iocq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (chain_ctl),
    .head  (head)
  );

endmodule

`default_nettype wire
